FILE: hdl/vstw_pkg.sv
// ----------------------------------------------------------------------------
// vstw_pkg: shared types and constants of the framebuffer transfer writer
// Framebuffer geometry, channel payload structs, queue entry and state codes.
// ----------------------------------------------------------------------------
package vstw_pkg;

    localparam int FB_WIDTH  = 1024;
    localparam int FB_HEIGHT = 512;

    localparam int WORD_W = 32;
    localparam int HALF_W = 16;
    localparam int CMD_W  = 8;

    localparam logic [CMD_W-1:0] HEADER_CODE = 8'hA0;

    localparam int X_W  = $clog2(FB_WIDTH);
    localparam int Y_W  = $clog2(FB_HEIGHT);
    localparam int RW_W = $clog2(FB_WIDTH + 1);
    localparam int RH_W = $clog2(FB_HEIGHT + 1);
    localparam int PL_W = $clog2(FB_WIDTH * FB_HEIGHT + 1);

    // Reduction of a 16-bit coordinate modulo the framebuffer size is done
    // with a reciprocal multiply followed by one correcting subtraction.
    localparam int     PROD_W   = 2 * HALF_W + 1;
    localparam int     X_SHIFT  = HALF_W + X_W;
    localparam int     Y_SHIFT  = HALF_W + Y_W;
    localparam longint X_RECIP  = (64'd1 << X_SHIFT) / FB_WIDTH;
    localparam longint Y_RECIP  = (64'd1 << Y_SHIFT) / FB_HEIGHT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              sink_ready;
    } in_t;

    typedef struct packed {
        logic              accepted;
        logic              write_valid;
        logic [X_W-1:0]    pixel_x;
        logic [Y_W-1:0]    pixel_y;
        logic [HALF_W-1:0] pixel_value;
        logic              transfer_done;
        logic              last;
    } out_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_POSITION,
        PH_SIZE,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ENT_REJECT,
        ENT_ACK,
        ENT_POS,
        ENT_SIZE,
        ENT_DATA
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t         kind;
        logic [WORD_W-1:0] word;
        logic [RW_W-1:0]   rect_w;
        logic              pair;
        logic              done;
    } entry_t;

endpackage

FILE: hdl/vstw_front.sv
// ----------------------------------------------------------------------------
// vstw_front: command decoder of the transfer writer
// Accepts stream words, tracks the transfer phase and pixel budget, and
// queues one classified entry per accepted word.
// ----------------------------------------------------------------------------
module vstw_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  vstw_pkg::in_t   s_data,
    output logic            push,
    output vstw_pkg::entry_t push_entry,
    input  logic            queue_full
);

    vstw_pkg::phase_t                phase_reg, phase_next;
    logic [vstw_pkg::PL_W-1:0]       pixels_left_reg, pixels_left_next;

    logic                            take;
    logic                            is_header;
    logic [vstw_pkg::HALF_W-1:0]     w_raw, h_raw, w_eff, h_eff;
    logic                            oversize;
    logic [vstw_pkg::RW_W-1:0]       rect_w;
    logic [vstw_pkg::RH_W-1:0]       rect_h;
    logic [vstw_pkg::PL_W-1:0]       area;
    logic                            data_ok;
    logic                            pair;
    logic [vstw_pkg::PL_W-1:0]       left_after;

    assign s_ready = !queue_full;
    assign take    = s_valid && s_ready;

    assign is_header = s_data.word[vstw_pkg::WORD_W-1 -: vstw_pkg::CMD_W]
                       == vstw_pkg::HEADER_CODE;

    assign w_raw = s_data.word[vstw_pkg::HALF_W-1:0];
    assign h_raw = s_data.word[vstw_pkg::WORD_W-1:vstw_pkg::HALF_W];
    assign w_eff = (w_raw == '0) ? vstw_pkg::HALF_W'(vstw_pkg::FB_WIDTH) : w_raw;
    assign h_eff = (h_raw == '0) ? vstw_pkg::HALF_W'(vstw_pkg::FB_HEIGHT) : h_raw;
    assign oversize = (w_eff > vstw_pkg::HALF_W'(vstw_pkg::FB_WIDTH))
                   || (h_eff > vstw_pkg::HALF_W'(vstw_pkg::FB_HEIGHT));
    assign rect_w = vstw_pkg::RW_W'(w_eff);
    assign rect_h = vstw_pkg::RH_W'(h_eff);
    assign area   = vstw_pkg::PL_W'(rect_w) * vstw_pkg::PL_W'(rect_h);

    assign data_ok    = (pixels_left_reg != '0) && s_data.sink_ready;
    assign pair       = pixels_left_reg >= vstw_pkg::PL_W'(2);
    assign left_after = pixels_left_reg - (pair ? vstw_pkg::PL_W'(2) : vstw_pkg::PL_W'(1));

    // Next phase and pixel budget.
    always_comb begin
        phase_next       = phase_reg;
        pixels_left_next = pixels_left_reg;
        if (take) begin
            unique case (phase_reg)
                vstw_pkg::PH_IDLE: begin
                    if (is_header) begin
                        phase_next = vstw_pkg::PH_POSITION;
                    end
                end
                vstw_pkg::PH_POSITION: begin
                    phase_next = vstw_pkg::PH_SIZE;
                end
                vstw_pkg::PH_SIZE: begin
                    if (!oversize) begin
                        phase_next       = vstw_pkg::PH_DATA;
                        pixels_left_next = area;
                    end
                end
                vstw_pkg::PH_DATA: begin
                    if (data_ok) begin
                        pixels_left_next = left_after;
                        if (left_after == '0) begin
                            phase_next = vstw_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    phase_next = vstw_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Queue entry for the accepted word.
    always_comb begin
        push              = take;
        push_entry        = '0;
        push_entry.kind   = vstw_pkg::ENT_REJECT;
        push_entry.word   = s_data.word;
        push_entry.rect_w = rect_w;
        push_entry.pair   = pair;
        push_entry.done   = (left_after == '0);
        unique case (phase_reg)
            vstw_pkg::PH_IDLE: begin
                push_entry.kind = is_header ? vstw_pkg::ENT_ACK : vstw_pkg::ENT_REJECT;
            end
            vstw_pkg::PH_POSITION: begin
                push_entry.kind = vstw_pkg::ENT_POS;
            end
            vstw_pkg::PH_SIZE: begin
                push_entry.kind = oversize ? vstw_pkg::ENT_REJECT : vstw_pkg::ENT_SIZE;
            end
            vstw_pkg::PH_DATA: begin
                push_entry.kind = data_ok ? vstw_pkg::ENT_DATA : vstw_pkg::ENT_REJECT;
            end
            default: begin
                push_entry.kind = vstw_pkg::ENT_REJECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= vstw_pkg::PH_IDLE;
            pixels_left_reg <= '0;
        end else begin
            phase_reg       <= phase_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

endmodule

FILE: hdl/vstw_queue.sv
// ----------------------------------------------------------------------------
// vstw_queue: entry queue between decoder and write engine
// A small first-in first-out buffer of classified entries.
// ----------------------------------------------------------------------------
module vstw_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  vstw_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output vstw_pkg::entry_t head_entry
);

    vstw_pkg::entry_t                slots_reg [vstw_pkg::QUEUE_DEPTH];
    logic [vstw_pkg::QP_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [vstw_pkg::QP_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [vstw_pkg::QC_W-1:0]       count_reg, count_next;

    assign full       = count_reg == vstw_pkg::QC_W'(vstw_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == vstw_pkg::QP_W'(vstw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == vstw_pkg::QP_W'(vstw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/vstw_back.sv
// ----------------------------------------------------------------------------
// vstw_back: write engine of the transfer writer
// Turns queued entries into results: acknowledgments, rejections and one
// framebuffer write per pixel, with wrapped addresses.
// ----------------------------------------------------------------------------
module vstw_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  vstw_pkg::entry_t head_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output vstw_pkg::out_t   m_data
);

    logic                          out_valid_reg, out_valid_next;
    vstw_pkg::out_t                out_data_reg, out_data_next;
    logic                          half_reg, half_next;
    logic                          mod_reg, mod_next;
    logic [vstw_pkg::X_W-1:0]      col_reg, col_next;
    logic [vstw_pkg::Y_W-1:0]      row_reg, row_next;
    logic [vstw_pkg::X_W-1:0]      base_x_reg, base_x_next;
    logic [vstw_pkg::Y_W-1:0]      base_y_reg, base_y_next;
    logic [vstw_pkg::RW_W-1:0]     width_reg, width_next;
    logic [vstw_pkg::HALF_W-1:0]   qx_reg, qx_next;
    logic [vstw_pkg::HALF_W-1:0]   qy_reg, qy_next;

    logic                          can_load;
    logic [vstw_pkg::HALF_W-1:0]   pos_x, pos_y;
    logic [vstw_pkg::PROD_W-1:0]   prod_x, prod_y;
    logic [vstw_pkg::HALF_W-1:0]   rem_x, rem_y;
    logic [vstw_pkg::HALF_W-1:0]   mod_x, mod_y;
    logic [vstw_pkg::X_W:0]        sum_x;
    logic [vstw_pkg::Y_W:0]        sum_y;
    logic [vstw_pkg::X_W-1:0]      wr_x;
    logic [vstw_pkg::Y_W-1:0]      wr_y;
    logic [vstw_pkg::RW_W-1:0]     col_inc;
    logic                          is_last;

    assign can_load = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // Position reduction, first step: quotient estimate, registered.
    assign pos_x  = head_entry.word[vstw_pkg::HALF_W-1:0];
    assign pos_y  = head_entry.word[vstw_pkg::WORD_W-1:vstw_pkg::HALF_W];
    assign prod_x = vstw_pkg::PROD_W'(pos_x) * vstw_pkg::PROD_W'(vstw_pkg::X_RECIP);
    assign prod_y = vstw_pkg::PROD_W'(pos_y) * vstw_pkg::PROD_W'(vstw_pkg::Y_RECIP);

    // Second step: remainder, off by at most one modulus.
    assign rem_x = pos_x - vstw_pkg::HALF_W'(qx_reg * vstw_pkg::HALF_W'(vstw_pkg::FB_WIDTH));
    assign rem_y = pos_y - vstw_pkg::HALF_W'(qy_reg * vstw_pkg::HALF_W'(vstw_pkg::FB_HEIGHT));
    assign mod_x = (rem_x >= vstw_pkg::HALF_W'(vstw_pkg::FB_WIDTH))
                   ? rem_x - vstw_pkg::HALF_W'(vstw_pkg::FB_WIDTH) : rem_x;
    assign mod_y = (rem_y >= vstw_pkg::HALF_W'(vstw_pkg::FB_HEIGHT))
                   ? rem_y - vstw_pkg::HALF_W'(vstw_pkg::FB_HEIGHT) : rem_y;

    // Write address; both operands are below the framebuffer size.
    assign sum_x = (vstw_pkg::X_W + 1)'(base_x_reg) + (vstw_pkg::X_W + 1)'(col_reg);
    assign sum_y = (vstw_pkg::Y_W + 1)'(base_y_reg) + (vstw_pkg::Y_W + 1)'(row_reg);
    assign wr_x  = (sum_x >= (vstw_pkg::X_W + 1)'(vstw_pkg::FB_WIDTH))
                   ? vstw_pkg::X_W'(sum_x - (vstw_pkg::X_W + 1)'(vstw_pkg::FB_WIDTH))
                   : vstw_pkg::X_W'(sum_x);
    assign wr_y  = (sum_y >= (vstw_pkg::Y_W + 1)'(vstw_pkg::FB_HEIGHT))
                   ? vstw_pkg::Y_W'(sum_y - (vstw_pkg::Y_W + 1)'(vstw_pkg::FB_HEIGHT))
                   : vstw_pkg::Y_W'(sum_y);

    assign col_inc = vstw_pkg::RW_W'(col_reg) + 1'b1;
    assign is_last = !head_entry.pair || half_reg;

    always_comb begin
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        half_next      = half_reg;
        mod_next       = mod_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_x_next    = base_x_reg;
        base_y_next    = base_y_reg;
        width_next     = width_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        if (head_valid && can_load) begin
            unique case (head_entry.kind)
                vstw_pkg::ENT_REJECT: begin
                    pop                = 1'b1;
                    out_valid_next     = 1'b1;
                    out_data_next      = '0;
                    out_data_next.last = 1'b1;
                end
                vstw_pkg::ENT_ACK: begin
                    pop                    = 1'b1;
                    out_valid_next         = 1'b1;
                    out_data_next          = '0;
                    out_data_next.accepted = 1'b1;
                    out_data_next.last     = 1'b1;
                end
                vstw_pkg::ENT_POS: begin
                    if (!mod_reg) begin
                        mod_next = 1'b1;
                        qx_next  = vstw_pkg::HALF_W'(prod_x >> vstw_pkg::X_SHIFT);
                        qy_next  = vstw_pkg::HALF_W'(prod_y >> vstw_pkg::Y_SHIFT);
                    end else begin
                        mod_next               = 1'b0;
                        pop                    = 1'b1;
                        base_x_next            = vstw_pkg::X_W'(mod_x);
                        base_y_next            = vstw_pkg::Y_W'(mod_y);
                        out_valid_next         = 1'b1;
                        out_data_next          = '0;
                        out_data_next.accepted = 1'b1;
                        out_data_next.last     = 1'b1;
                    end
                end
                vstw_pkg::ENT_SIZE: begin
                    pop                    = 1'b1;
                    width_next             = head_entry.rect_w;
                    col_next               = '0;
                    row_next               = '0;
                    out_valid_next         = 1'b1;
                    out_data_next          = '0;
                    out_data_next.accepted = 1'b1;
                    out_data_next.last     = 1'b1;
                end
                vstw_pkg::ENT_DATA: begin
                    out_valid_next              = 1'b1;
                    out_data_next.accepted      = 1'b1;
                    out_data_next.write_valid   = 1'b1;
                    out_data_next.pixel_x       = wr_x;
                    out_data_next.pixel_y       = wr_y;
                    out_data_next.pixel_value   = half_reg
                        ? head_entry.word[vstw_pkg::WORD_W-1:vstw_pkg::HALF_W]
                        : head_entry.word[vstw_pkg::HALF_W-1:0];
                    out_data_next.transfer_done = head_entry.done && is_last;
                    out_data_next.last          = is_last;
                    if (col_inc >= width_reg) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        col_next = vstw_pkg::X_W'(col_inc);
                    end
                    if (is_last) begin
                        pop       = 1'b1;
                        half_next = 1'b0;
                        if (head_entry.done) begin
                            col_next = '0;
                            row_next = '0;
                        end
                    end else begin
                        half_next = 1'b1;
                    end
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            mod_reg       <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            mod_reg       <= mod_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        base_x_reg   <= base_x_next;
        base_y_reg   <= base_y_next;
        width_reg    <= width_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
    end

endmodule

FILE: hdl/vram_store_transfer_writer.sv
// ----------------------------------------------------------------------------
// vram_store_transfer_writer: CPU-to-framebuffer rectangle transfer writer
// Decodes a header, position, size and pixel-data stream into per-pixel
// framebuffer writes with wrapped addresses.
// ----------------------------------------------------------------------------
// Usage. Command words arrive on the s_ channel (valid/ready); each accepted
// transaction carries one 32-bit word and the sink_ready flag sampled with
// it. Results leave on the m_ channel (valid/ready), one transaction per
// result: one for a header, position, size or rejected word, and one per
// pixel for a data word (two, or one for the odd final pixel), the final
// one of each word flagged by last.
// Each accepted word passes through the queue and the registered output;
// the position word also passes through the quotient register, as its
// coordinates are reduced modulo the framebuffer size by a reciprocal multiply.
// Throughput is set by the write engine, which, while the receiver is
// ready, emits one result per cycle, one per pixel of a data word, and
// none in the quotient step of the position word. A four-entry queue
// parts the decoder from the engine, so the input keeps being accepted
// while the engine or the receiver is busy. When the receiver stalls, the
// registered result holds and the queue fills; s_ready falls only once
// the queue is full. Reset clears the phase to idle, the pixel budget,
// the queue and the output valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vram_store_transfer_writer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vstw_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output vstw_pkg::out_t m_data
);

    // Decoder to queue.
    logic             push;
    vstw_pkg::entry_t push_entry;
    logic             queue_full;

    // Queue to write engine.
    logic             pop;
    logic             head_valid;
    vstw_pkg::entry_t head_entry;

    // The decoder owns the transfer phase and the remaining pixel count, so it
    // can classify every word at once, including rejections of data words.
    vstw_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    vstw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // The write engine owns the origin, the width and the column and row
    // walk; entries reach it in order, so its view stays consistent.
    vstw_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: hdl/vstw_checker.sv
// ----------------------------------------------------------------------------
// vstw_checker: port-level checks of the transfer writer
// Watches both channels for handshake and result consistency.
// ----------------------------------------------------------------------------
module vstw_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input vstw_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input vstw_pkg::out_t m_data
);

    // A waiting input transaction holds its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input changed");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A pixel write is always part of an accepted word.
    a_write_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_valid |-> m_data.accepted)
        else $error("write on a rejected word");

    // Only the final result of a word may complete the rectangle.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.transfer_done |-> m_data.last && m_data.write_valid)
        else $error("completion not on final write");

    // Words without pixel writes yield exactly one result.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_valid |-> m_data.last && m_data.pixel_value == '0)
        else $error("non-write result malformed");

endmodule

bind vram_store_transfer_writer vstw_checker u_vstw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the framebuffer transfer writer
// Feeds header, position, size and pixel-data transactions with random gaps,
// predicts every framebuffer write, and checks each result in order against
// that prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // A pending input transaction. When hold_for_drain is set, the driver
    // keeps it back until every result predicted so far has been received.
    typedef struct {
        vstw_pkg::in_t item;
        bit            hold_for_drain;
    } pending_t;

    localparam int WORD_BUDGET = 1450;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    vstw_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    vstw_pkg::out_t m_data;

    pending_t       pending_words[$];
    vstw_pkg::out_t expected_writes[$];

    // Results are counted on both sides with nonblocking updates, so the
    // driver sees a stable picture of what is still in flight at each edge.
    int unsigned n_predicted = 0;
    int unsigned n_received  = 0;
    int unsigned words_queued = 0;
    int unsigned fail_count = 0;

    int  send_gap   = 0;
    int  stall_left = 0;
    bit  burst_send = 1'b0;
    bit  burst_recv = 1'b0;

    // Mirror of the block's transfer state, kept at the block's own widths.
    // The column and row counters are one bit wider than an address, since
    // they run up to the full rectangle size before wrapping.
    vstw_pkg::phase_t          cur_phase;
    logic [vstw_pkg::X_W-1:0]  base_x;
    logic [vstw_pkg::Y_W-1:0]  base_y;
    logic [vstw_pkg::RW_W-1:0] rect_width;
    logic [vstw_pkg::RW_W-1:0] column;
    logic [vstw_pkg::RH_W-1:0] row;
    logic [vstw_pkg::PL_W-1:0] pixels_left;

    vram_store_transfer_writer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Every field of the transfer state goes back to its reset value, both at
    // reset and once a rectangle has been completely written.
    function automatic void clear_transfer_state();
        cur_phase   = vstw_pkg::PH_IDLE;
        base_x      = '0;
        base_y      = '0;
        rect_width  = '0;
        column      = '0;
        row         = '0;
        pixels_left = '0;
    endfunction

    // Works out the results that one accepted transaction causes, appends
    // them to the expected queue and returns how many there are.
    function automatic int predict_writes(input vstw_pkg::in_t it);
        vstw_pkg::out_t r;
        int unsigned    wd;
        int unsigned    ht;
        int unsigned    npix;
        int unsigned    k;
        r = '0;
        r.last = 1'b1;
        case (cur_phase)
            vstw_pkg::PH_IDLE: begin
                // Anything but the transfer header is refused while idle.
                if (it.word[31:24] == vstw_pkg::HEADER_CODE) begin
                    cur_phase = vstw_pkg::PH_POSITION;
                    r.accepted = 1'b1;
                end
            end
            vstw_pkg::PH_POSITION: begin
                base_x = vstw_pkg::X_W'(int'(it.word[15:0]) % vstw_pkg::FB_WIDTH);
                base_y = vstw_pkg::Y_W'(int'(it.word[31:16]) % vstw_pkg::FB_HEIGHT);
                cur_phase = vstw_pkg::PH_SIZE;
                r.accepted = 1'b1;
            end
            vstw_pkg::PH_SIZE: begin
                // A zero size stands for the full framebuffer extent, and an
                // oversize rectangle is refused with the phase left as it is.
                wd = 32'(it.word[15:0]);
                ht = 32'(it.word[31:16]);
                if (wd == 0) wd = vstw_pkg::FB_WIDTH;
                if (ht == 0) ht = vstw_pkg::FB_HEIGHT;
                if (wd <= vstw_pkg::FB_WIDTH && ht <= vstw_pkg::FB_HEIGHT) begin
                    rect_width  = vstw_pkg::RW_W'(wd);
                    column      = '0;
                    row         = '0;
                    pixels_left = vstw_pkg::PL_W'(wd * ht);
                    cur_phase   = vstw_pkg::PH_DATA;
                    r.accepted  = 1'b1;
                end
            end
            vstw_pkg::PH_DATA: begin
                if (pixels_left != 0 && it.sink_ready) begin
                    // Low half first; with a single pixel left the high half
                    // of the word is dropped.
                    npix = (pixels_left >= 2) ? 2 : 1;
                    for (k = 0; k < npix; k++) begin
                        r.accepted    = 1'b1;
                        r.write_valid = 1'b1;
                        r.pixel_x = vstw_pkg::X_W'((int'(base_x) + int'(column))
                                                   % vstw_pkg::FB_WIDTH);
                        r.pixel_y = vstw_pkg::Y_W'((int'(base_y) + int'(row))
                                                   % vstw_pkg::FB_HEIGHT);
                        r.pixel_value = (k == 0) ? it.word[15:0] : it.word[31:16];
                        pixels_left = pixels_left - 1'b1;
                        r.transfer_done = (pixels_left == 0);
                        column = column + 1'b1;
                        if (column >= rect_width) begin
                            column = '0;
                            row = row + 1'b1;
                        end
                        r.last = (k == npix - 1);
                        expected_writes.push_back(r);
                    end
                    if (pixels_left == 0) clear_transfer_state();
                    return npix;
                end
            end
            default: ;
        endcase
        expected_writes.push_back(r);
        return 1;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one, and none
    // at all while a burst stretch is running.
    function automatic int draw_idle(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic void check_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic queue_word(input logic [31:0] w, input logic rdy, input bit hold);
        pending_t p;
        p.item.word       = w;
        p.item.sink_ready = rdy;
        p.hold_for_drain  = hold;
        pending_words.push_back(p);
        words_queued++;
    endtask

    // A word that the size phase must refuse: one of the two extents is
    // beyond the framebuffer, the other anything at all.
    function automatic logic [31:0] oversize_word();
        logic [15:0] wd;
        logic [15:0] ht;
        if ($urandom_range(0, 1) == 0) begin
            wd = 16'($urandom_range(vstw_pkg::FB_WIDTH + 1, 65535));
            ht = 16'($urandom);
        end else begin
            wd = 16'($urandom);
            ht = 16'($urandom_range(vstw_pkg::FB_HEIGHT + 1, 65535));
        end
        return {ht, wd};
    endfunction

    // One complete upload: header, position, an optional refused size, the
    // size, and exactly as many data words as the rectangle needs. Data words
    // sent while the sink is busy are refused and do not count.
    task automatic queue_transfer(input logic [31:0] pos_word, input logic [31:0] size_word,
                                  input bit bad_size_first, input bit hold);
        int unsigned wd;
        int unsigned ht;
        int unsigned left;
        logic        rdy;
        queue_word({vstw_pkg::HEADER_CODE, 24'($urandom)}, 1'($urandom), hold);
        queue_word(pos_word, 1'($urandom), 1'b0);
        if (bad_size_first) queue_word(oversize_word(), 1'($urandom), 1'b0);
        queue_word(size_word, 1'($urandom), 1'b0);
        wd = 32'(size_word[15:0]);
        ht = 32'(size_word[31:16]);
        if (wd == 0) wd = vstw_pkg::FB_WIDTH;
        if (ht == 0) ht = vstw_pkg::FB_HEIGHT;
        left = wd * ht;
        while (left > 0) begin
            rdy = ($urandom_range(0, 9) != 0);
            queue_word($urandom, rdy, 1'b0);
            if (rdy) left = (left >= 2) ? left - 2 : 0;
        end
    endtask

    // Driver. The payload is only replaced when no transaction is waiting,
    // so valid and data hold steady until the block takes them. Each
    // accepted transaction is run through the predictor on the same edge.
    always @(posedge aclk) begin
        int produced;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            send_gap <= 0;
            clear_transfer_state();
        end else begin
            if (s_valid && s_ready) begin
                produced = predict_writes(s_data);
                n_predicted <= n_predicted + produced;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             (!pending_words[0].hold_for_drain ||
                              (n_predicted == n_received && !(s_valid && s_ready)))) begin
                    s_data   <= pending_words[0].item;
                    s_valid  <= 1'b1;
                    send_gap <= draw_idle(burst_send);
                    pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 99) < 2) burst_send <= !burst_send;
        end
    end

    // Monitor. Each result transaction is matched against the oldest
    // prediction. The receiver stalls at random, with burst stretches in
    // which it starts no new stall.
    always @(posedge aclk) begin
        vstw_pkg::out_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(m_data.accepted));
                    check_field("write_valid", 32'(want.write_valid),
                                32'(m_data.write_valid));
                    check_field("pixel_x", 32'(want.pixel_x), 32'(m_data.pixel_x));
                    check_field("pixel_y", 32'(want.pixel_y), 32'(m_data.pixel_y));
                    check_field("pixel_value", 32'(want.pixel_value),
                                32'(m_data.pixel_value));
                    check_field("transfer_done", 32'(want.transfer_done),
                                32'(m_data.transfer_done));
                    check_field("last", 32'(want.last), 32'(m_data.last));
                    n_received <= n_received + 1;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!burst_recv && $urandom_range(0, 99) < 20) begin
                stall_left <= draw_idle(1'b0);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if ($urandom_range(0, 99) < 2) burst_recv <= !burst_recv;
        end
    end

    // Stimulus and end of run.
    initial begin
        int          r;
        logic [31:0] w;

        // Idle refusals: all zeros, all ones, and a header code one off.
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word({vstw_pkg::HEADER_CODE ^ 8'h01, 24'hFFFFFF}, 1'b1, 1'b0);
        // Header, then a position at the far corner so that writes wrap in
        // both directions.
        queue_word({vstw_pkg::HEADER_CODE, 24'hFFFFFF}, 1'b0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        // Oversize sizes are refused and the block keeps waiting for a size:
        // both extents too big, width one past the edge, height one past it.
        queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h0001_0401, 1'b1, 1'b0);
        queue_word(32'h0201_0400, 1'b1, 1'b0);
        // A 3 by 2 rectangle from the far corner.
        queue_word(32'h0002_0003, 1'b0, 1'b0);
        // Data while the sink is busy is refused.
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_word(32'hFFFF_0000, 1'b1, 1'b0);
        queue_word(32'h0000_FFFF, 1'b1, 1'b0);
        queue_word(32'h5A5A_A5A5, 1'b1, 1'b0);
        // A single pixel rectangle at the origin, held back until the block
        // has drained: the odd tail drops the high half of its word.
        queue_word({vstw_pkg::HEADER_CODE, 24'h000000}, 1'b1, 1'b1);
        queue_word(32'h0000_0000, 1'b1, 1'b0);
        queue_word(32'h0001_0001, 1'b0, 1'b0);
        queue_word(32'hFFFF_1234, 1'b1, 1'b0);

        // Zero width and zero height each once; they are the long transfers.
        queue_transfer($urandom, 32'h0001_0000, 1'b0, 1'b0);
        queue_transfer($urandom, 32'h0000_0001, 1'b1, 1'b0);

        // Mostly well-formed small uploads with random content, mixed with
        // idle noise and refused sizes.
        while (words_queued < WORD_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                w = $urandom;
                if (w[31:24] == vstw_pkg::HEADER_CODE) w[31] = 1'b0;
                queue_word(w, 1'($urandom), 1'b0);
            end else begin
                queue_transfer($urandom,
                               {16'($urandom_range(1, 6)), 16'($urandom_range(1, 12))},
                               ($urandom_range(0, 99) < 15),
                               ($urandom_range(0, 99) < 3));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last transaction to be taken and every predicted
        // result to come back, then wait on a while longer to catch strays.
        while (pending_words.size() > 0 || s_valid) @(posedge aclk);
        @(posedge aclk);
        while (n_predicted != n_received) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0 && expected_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake or a missing result.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hdl/vstw_pkg.sv
hdl/vstw_front.sv
hdl/vstw_queue.sv
hdl/vstw_back.sv
hdl/vram_store_transfer_writer.sv
hdl/vstw_checker.sv
bench/tb_top.sv
